/* hdl/istsu_pkg.sv */
// ============================================================================
// istsu_pkg
// Shared codes, field widths and types of the indexed sequential title
// search unit.
// ============================================================================
package istsu_pkg;

    // Input field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 5;
    localparam int POS_W    = 7;
    localparam int CHAR_W   = 8;
    localparam int IVAL_W   = 6;

    // Result field widths
    localparam int STATUS_W = 2;
    localparam int TPOS_W   = 6;

    // Configuration register
    localparam int COUNT_W  = 6;
    localparam logic [COUNT_W-1:0] TITLE_COUNT_RESET = 6'd32;

    // Title rank (1-based position, range bounds), holds up to 64 + 1
    localparam int RANK_W   = 7;

    // Stream data widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Operation codes on the input stream
    localparam logic [OP_W-1:0] OP_TITLE = 2'd0;
    localparam logic [OP_W-1:0] OP_INDEX = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ENTRY = 2'd2;

    // Kind of work handed to the back end
    typedef enum logic [1:0] {
        KIND_TITLE,
        KIND_INDEX,
        KIND_QUERY
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    pos;
        logic [CHAR_W-1:0]   ch;
        logic [IVAL_W-1:0]   ival;
        logic                last_char;
    } work_item_t;

    // One side of the queue: an entry plus its valid flag
    typedef struct packed {
        logic        valid;
        work_item_t  item;
    } queue_port_t;

endpackage

/* hdl/istsu_ram.sv */
// ============================================================================
// istsu_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ============================================================================
module istsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write first-come, read returns the old contents on a collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/istsu_front.sv */
// ============================================================================
// istsu_front
// Input side: takes stream transfers, drops unused operations and loads
// outside storage, and hands the rest to the queue as work items.
// ============================================================================
module istsu_front #(
    parameter int NUM_TITLES = 32,
    parameter int TITLE_LEN  = 128,
    parameter int INDEX_SIZE = 256
) (
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // fields from bit 0 up: title_slot, char_pos, char_value, index_value
    input  logic [istsu_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [istsu_pkg::OP_W-1:0]       s_axis_tuser,
    input  logic                             s_axis_tlast,
    input  logic                             init_done,
    input  logic                             queue_full,
    output istsu_pkg::queue_port_t           push
);

    istsu_pkg::work_item_t item;
    logic                  keep;

    // Unpack fields
    always_comb
    begin
        item.slot      = s_axis_tdata[4:0];
        item.pos       = s_axis_tdata[11:5];
        item.ch        = s_axis_tdata[19:12];
        item.ival      = s_axis_tdata[25:20];
        item.last_char = s_axis_tlast;
    end

    // Classify the operation, check load addresses against storage
    always_comb
    begin
        keep      = 1'b0;
        item.kind = istsu_pkg::KIND_QUERY;
        unique case (s_axis_tuser)
            istsu_pkg::OP_TITLE:
            begin
                item.kind = istsu_pkg::KIND_TITLE;
                keep      = (9'(item.slot) < 9'(NUM_TITLES)) && (9'(item.pos) < 9'(TITLE_LEN));
            end
            istsu_pkg::OP_INDEX:
            begin
                item.kind = istsu_pkg::KIND_INDEX;
                keep      = 9'(item.ch) < 9'(INDEX_SIZE);
            end
            istsu_pkg::OP_QUERY:
            begin
                item.kind = istsu_pkg::KIND_QUERY;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Handshake: dropped items are still taken
    assign s_axis_tready = init_done && !queue_full;
    assign push.valid    = s_axis_tvalid && s_axis_tready && keep;
    assign push.item     = item;

endmodule

/* hdl/istsu_queue.sv */
// ============================================================================
// istsu_queue
// Short register FIFO between the front and the back end.
// ============================================================================
module istsu_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  istsu_pkg::queue_port_t  push,
    output logic                    full,
    input  logic                    pop,
    output istsu_pkg::queue_port_t  head
);

    localparam int PTR_W = $clog2(istsu_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(istsu_pkg::QUEUE_DEPTH + 1);

    istsu_pkg::work_item_t slots_reg [istsu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full       = count_reg == CNT_W'(istsu_pkg::QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.item  = slots_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hdl/istsu_back.sv */
// ============================================================================
// istsu_back
// Back end: clears storage after reset, carries out loads, stores query
// characters and runs the search, one result at a time into the output
// register.
// ============================================================================
module istsu_back #(
    parameter int NUM_TITLES = 32,
    parameter int TITLE_LEN  = 128,
    parameter int INDEX_SIZE = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [istsu_pkg::COUNT_W-1:0]     title_count,
    input  istsu_pkg::queue_port_t            head,
    output logic                              pop,
    output logic                              init_done,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // title_position
    output logic [istsu_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [istsu_pkg::STATUS_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int TITLE_DEPTH = NUM_TITLES * TITLE_LEN;
    localparam int TA_W        = $clog2(TITLE_DEPTH);
    localparam int IX_W        = $clog2(INDEX_SIZE);
    localparam int QA_W        = $clog2(TITLE_LEN);
    localparam int QL_W        = $clog2(TITLE_LEN + 1);
    localparam int CLR_DEPTH   = (TITLE_DEPTH > INDEX_SIZE) ? TITLE_DEPTH : INDEX_SIZE;
    localparam int CLR_W       = $clog2(CLR_DEPTH);
    localparam int SCAN_W      = istsu_pkg::CHAR_W + 1;
    localparam int RANK_W      = istsu_pkg::RANK_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QHEAD,
        S_FIRST,
        S_LO,
        S_SCAN,
        S_SCAN_CHK,
        S_RANGE,
        S_CMP_RD,
        S_CMP_EV,
        S_EMIT
    } state_t;

    state_t                              state_reg,      state_next;
    logic [CLR_W-1:0]                    clr_cnt_reg,    clr_cnt_next;
    logic [QL_W-1:0]                     qlen_reg,       qlen_next;
    logic                                first_ok_reg,   first_ok_next;
    logic [SCAN_W-1:0]                   scan_reg,       scan_next;
    logic [RANK_W-1:0]                   lo_reg,         lo_next;
    logic [RANK_W-1:0]                   hi_reg,         hi_next;
    logic [RANK_W-1:0]                   p_reg,          p_next;
    logic [TA_W-1:0]                     base_reg,       base_next;
    logic [QL_W-1:0]                     cidx_reg,       cidx_next;
    logic [istsu_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic                                res_last_reg,   res_last_next;
    logic                                m_valid_reg,    m_valid_next;
    logic [istsu_pkg::STATUS_W-1:0]      m_status_reg,   m_status_next;
    logic [istsu_pkg::TPOS_W-1:0]        m_pos_reg,      m_pos_next;
    logic                                m_last_reg,     m_last_next;

    // Memory ports
    logic                                t_wr_en;
    logic [TA_W-1:0]                     t_wr_addr;
    logic [istsu_pkg::CHAR_W-1:0]        t_wr_data;
    logic [TA_W-1:0]                     t_rd_addr;
    logic [istsu_pkg::CHAR_W-1:0]        t_rd;
    logic                                x_wr_en;
    logic [IX_W-1:0]                     x_wr_addr;
    logic [istsu_pkg::IVAL_W-1:0]        x_wr_data;
    logic [IX_W-1:0]                     x_rd_addr;
    logic [istsu_pkg::IVAL_W-1:0]        x_rd;
    logic                                q_wr_en;
    logic [QA_W-1:0]                     q_rd_addr;
    logic [istsu_pkg::CHAR_W-1:0]        q_rd;

    logic [RANK_W-1:0]                   limit;
    logic [RANK_W-1:0]                   lim1;
    logic [RANK_W-1:0]                   x_rank;
    logic                                clr_title;
    logic                                clr_index;
    logic                                t_end;
    logic                                q_end;
    logic                                at_last;

    // Title store, index table, query buffer
    istsu_ram #(.WIDTH(istsu_pkg::CHAR_W), .DEPTH(TITLE_DEPTH)) u_title_ram (
        .clk     (clk),
        .wr_en   (t_wr_en),
        .wr_addr (t_wr_addr),
        .wr_data (t_wr_data),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd)
    );

    istsu_ram #(.WIDTH(istsu_pkg::IVAL_W), .DEPTH(INDEX_SIZE)) u_index_ram (
        .clk     (clk),
        .wr_en   (x_wr_en),
        .wr_addr (x_wr_addr),
        .wr_data (x_wr_data),
        .rd_addr (x_rd_addr),
        .rd_data (x_rd)
    );

    istsu_ram #(.WIDTH(istsu_pkg::CHAR_W), .DEPTH(TITLE_LEN)) u_query_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (qlen_reg[QA_W-1:0]),
        .wr_data (head.item.ch),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd)
    );

    // Range limit: title count saturated at the store size
    assign limit = (RANK_W'(title_count) > RANK_W'(NUM_TITLES)) ?
                   RANK_W'(NUM_TITLES) : RANK_W'(title_count);
    assign lim1  = limit + 1'b1;
    assign x_rank = RANK_W'(x_rd);

    // Clear sweep coverage of each memory
    assign clr_title = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(TITLE_DEPTH);
    assign clr_index = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(INDEX_SIZE);

    // Write side addressing: clear sweep or load item
    assign t_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg[TA_W-1:0] :
                       TA_W'(int'(head.item.slot) * TITLE_LEN + int'(head.item.pos));
    assign t_wr_data = (state_reg == S_CLEAR) ? '0 : head.item.ch;
    assign x_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg[IX_W-1:0] : head.item.ch[IX_W-1:0];
    assign x_wr_data = (state_reg == S_CLEAR) ? '0 : head.item.ival;

    // Read side addressing
    assign t_rd_addr = base_reg + TA_W'(cidx_reg);
    assign q_rd_addr = (state_reg == S_QHEAD) ? '0 : cidx_reg[QA_W-1:0];
    assign x_rd_addr = (state_reg == S_FIRST) ? q_rd[IX_W-1:0] : scan_reg[IX_W-1:0];

    // String end detection for one compare step
    assign t_end   = (cidx_reg >= QL_W'(TITLE_LEN)) || (t_rd == '0);
    assign q_end   = (cidx_reg >= qlen_reg) || (q_rd == '0);
    assign at_last = (p_reg + 1'b1) == hi_reg;

    assign init_done = state_reg != S_CLEAR;

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        qlen_next       = qlen_reg;
        first_ok_next   = first_ok_reg;
        scan_next       = scan_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        p_next          = p_reg;
        base_next       = base_reg;
        cidx_next       = cidx_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_status_next   = m_status_reg;
        m_pos_next      = m_pos_reg;
        m_last_next     = m_last_reg;
        pop             = 1'b0;
        t_wr_en         = 1'b0;
        x_wr_en         = 1'b0;
        q_wr_en         = 1'b0;

        unique case (state_reg)
            // Zero both tables after reset
            S_CLEAR:
            begin
                t_wr_en = clr_title;
                x_wr_en = clr_index;
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            // Take the next work item
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.item.kind)
                        istsu_pkg::KIND_TITLE: t_wr_en = 1'b1;
                        istsu_pkg::KIND_INDEX: x_wr_en = 1'b1;
                        istsu_pkg::KIND_QUERY:
                        begin
                            // characters past capacity are dropped
                            if (qlen_reg < QL_W'(TITLE_LEN))
                            begin
                                q_wr_en   = 1'b1;
                                qlen_next = qlen_reg + 1'b1;
                            end
                            if (head.item.last_char)
                            begin
                                state_next = S_QHEAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Read the first query character
            S_QHEAD:
            begin
                state_next = S_FIRST;
            end

            // Look up its index entry, start the scan just past it
            S_FIRST:
            begin
                first_ok_next = {1'b0, q_rd} < SCAN_W'(INDEX_SIZE);
                scan_next     = SCAN_W'(q_rd) + 1'b1;
                state_next    = S_LO;
            end

            S_LO:
            begin
                lo_next    = first_ok_reg ? x_rank : '0;
                state_next = S_SCAN;
            end

            // Walk forward to the next nonzero entry
            S_SCAN:
            begin
                if (scan_reg >= SCAN_W'(INDEX_SIZE))
                begin
                    hi_next    = lim1;
                    state_next = S_RANGE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (x_rd != '0)
                begin
                    hi_next    = (x_rank > lim1) ? lim1 : x_rank;
                    state_next = S_RANGE;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end

            // Empty range gives one not-found result
            S_RANGE:
            begin
                if ((lo_reg == '0) || (lo_reg >= hi_reg))
                begin
                    res_status_next = istsu_pkg::STATUS_NO_ENTRY;
                    res_last_next   = 1'b1;
                    p_next          = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    p_next     = lo_reg;
                    base_next  = TA_W'((int'(lo_reg) - 1) * TITLE_LEN);
                    cidx_next  = '0;
                    state_next = S_CMP_RD;
                end
            end

            // Compare one character pair: read, then evaluate
            S_CMP_RD:
            begin
                state_next = S_CMP_EV;
            end

            S_CMP_EV:
            begin
                res_last_next = at_last;
                if (t_end && q_end)
                begin
                    res_status_next = istsu_pkg::STATUS_MATCH;
                    state_next      = S_EMIT;
                end
                else if (t_end || q_end || (t_rd != q_rd))
                begin
                    res_status_next = istsu_pkg::STATUS_NO_MATCH;
                    state_next      = S_EMIT;
                end
                else
                begin
                    cidx_next  = cidx_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end

            // Hand the result to the output register
            S_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_pos_next    = p_reg[istsu_pkg::TPOS_W-1:0];
                    m_last_next   = res_last_reg;
                    if (res_last_reg)
                    begin
                        qlen_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        base_next  = base_reg + TA_W'(TITLE_LEN);
                        cidx_next  = '0;
                        state_next = S_CMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            qlen_reg       <= '0;
            first_ok_reg   <= 1'b0;
            scan_reg       <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            p_reg          <= '0;
            base_reg       <= '0;
            cidx_reg       <= '0;
            res_status_reg <= istsu_pkg::STATUS_NO_MATCH;
            res_last_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= istsu_pkg::STATUS_NO_MATCH;
            m_pos_reg      <= '0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            qlen_reg       <= qlen_next;
            first_ok_reg   <= first_ok_next;
            scan_reg       <= scan_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            p_reg          <= p_next;
            base_reg       <= base_next;
            cidx_reg       <= cidx_next;
            res_status_reg <= res_status_next;
            res_last_reg   <= res_last_next;
            m_valid_reg    <= m_valid_next;
            m_status_reg   <= m_status_next;
            m_pos_reg      <= m_pos_next;
            m_last_reg     <= m_last_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = istsu_pkg::M_DATA_W'(m_pos_reg);
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

/* hdl/indexed_sequential_title_search_unit.sv */
// ============================================================================
// indexed_sequential_title_search_unit
// Keeps NUM_TITLES zero-terminated titles and a first-character index table,
// and searches the titles of one index group for a query string.
// After reset the unit zeroes the title store and the index table in a sweep
// over max(NUM_TITLES * TITLE_LEN, INDEX_SIZE) addresses (4096 at the defaults),
// during which s_axis_tready stays low; configuration writes are taken at
// any time. The front end then takes one transfer per cycle into a
// four-entry queue while it has room; the back end retires loads and query
// characters one at a time while it is not searching. A transfer with last
// set starts the search, which runs one item at a time: it fetches the
// query's first character and its index entry, scans later index entries up
// to the next nonzero one, sets the range, then for each title in range
// compares one character pair at a time (up to the shorter length plus one)
// and hands the result over, waiting on m_axis_tready while the result
// register is full. Titles are read for the compare through the one read
// port of the title memory. A query that finds no index entry gives one
// result with status 2 and position 0.
// ============================================================================
module indexed_sequential_title_search_unit #(
    parameter int NUM_TITLES = 32,
    parameter int TITLE_LEN  = 128,
    parameter int INDEX_SIZE = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // title_count register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [istsu_pkg::COUNT_W-1:0]     cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // fields from bit 0 up: title_slot[4:0], char_pos[11:5], char_value[19:12],
    // index_value[25:20], zeros above
    input  logic [istsu_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // op
    input  logic [istsu_pkg::OP_W-1:0]        s_axis_tuser,
    // last_char
    input  logic                              s_axis_tlast,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // fields from bit 0 up: title_position[5:0], zeros above
    output logic [istsu_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [istsu_pkg::STATUS_W-1:0]    m_axis_tuser,
    // last
    output logic                              m_axis_tlast
);

    logic [istsu_pkg::COUNT_W-1:0] title_count_reg;
    istsu_pkg::queue_port_t        push;
    istsu_pkg::queue_port_t        head;
    logic                          queue_full;
    logic                          pop;
    logic                          init_done;

    // title_count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            title_count_reg <= istsu_pkg::TITLE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            title_count_reg <= cfg_data;
        end
    end

    // Accept and classify
    istsu_front #(
        .NUM_TITLES (NUM_TITLES),
        .TITLE_LEN  (TITLE_LEN),
        .INDEX_SIZE (INDEX_SIZE)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .init_done     (init_done),
        .queue_full    (queue_full),
        .push          (push)
    );

    // Work queue
    istsu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .head  (head)
    );

    // Storage, search and result register
    istsu_back #(
        .NUM_TITLES (NUM_TITLES),
        .TITLE_LEN  (TITLE_LEN),
        .INDEX_SIZE (INDEX_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .title_count   (title_count_reg),
        .head          (head),
        .pop           (pop),
        .init_done     (init_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* tb/title_search_checker.sv */
// ============================================================================
// title_search_checker
// Watches the configuration, input and result channels of the title search
// unit. Keeps its own title store, first-character index, query buffer and
// title count, predicts the results of each search and compares every result
// transfer, field by field, with the oldest predicted one.
// ============================================================================
module title_search_checker #(
    parameter int NUM_TITLES = 32,
    parameter int TITLE_LEN  = 128,
    parameter int INDEX_SIZE = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [istsu_pkg::COUNT_W-1:0]     cfg_data,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // title_slot, char_pos, char_value, index_value, zeros above
    input  logic [istsu_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // op
    input  logic [istsu_pkg::OP_W-1:0]        s_axis_tuser,
    // last_char
    input  logic                              s_axis_tlast,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // title_position, zeros above
    input  logic [istsu_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // status
    input  logic [istsu_pkg::STATUS_W-1:0]    m_axis_tuser,
    // last
    input  logic                              m_axis_tlast,
    output int                                fail_count,
    output int                                results_pending
);

    typedef struct packed {
        logic [istsu_pkg::STATUS_W-1:0] status;
        logic [istsu_pkg::TPOS_W-1:0]   position;
        logic                           last;
    } title_result_t;

    logic [istsu_pkg::CHAR_W-1:0]  title_chars [NUM_TITLES*TITLE_LEN];
    logic [istsu_pkg::IVAL_W-1:0]  first_char_index [INDEX_SIZE];
    logic [istsu_pkg::CHAR_W-1:0]  query_chars [TITLE_LEN];
    int                            query_len;
    logic [istsu_pkg::COUNT_W-1:0] title_count;
    title_result_t                 expected_titles [$];
    title_result_t                 oldest;

    // Input transfer fields
    logic [istsu_pkg::SLOT_W-1:0]  in_slot;
    logic [istsu_pkg::POS_W-1:0]   in_pos;
    logic [istsu_pkg::CHAR_W-1:0]  in_char;
    logic [istsu_pkg::IVAL_W-1:0]  in_ival;

    assign in_slot = s_axis_tdata[istsu_pkg::SLOT_W-1:0];
    assign in_pos  = s_axis_tdata[istsu_pkg::SLOT_W +: istsu_pkg::POS_W];
    assign in_char = s_axis_tdata[istsu_pkg::SLOT_W + istsu_pkg::POS_W +: istsu_pkg::CHAR_W];
    assign in_ival = s_axis_tdata[istsu_pkg::SLOT_W + istsu_pkg::POS_W + istsu_pkg::CHAR_W +:
                                  istsu_pkg::IVAL_W];

    // Both strings end at their first NUL, or at the full length
    function automatic bit title_equals_query(input int slot);
        int tlen;
        int qlen;
        bit same;
        tlen = TITLE_LEN;
        qlen = query_len;
        same = 1'b1;
        for (int i = TITLE_LEN - 1; i >= 0; i--)
            if (title_chars[slot*TITLE_LEN + i] == 0)
                tlen = i;
        for (int i = query_len - 1; i >= 0; i--)
            if (query_chars[i] == 0)
                qlen = i;
        if (tlen != qlen)
            same = 1'b0;
        else
            for (int i = 0; i < qlen; i++)
                if (title_chars[slot*TITLE_LEN + i] != query_chars[i])
                    same = 1'b0;
        return same;
    endfunction

    // Group of the query's first character: one result per title in range, else one not-found result
    function automatic void search_titles();
        int first;
        int lo;
        int hi;
        int limit;
        bit found;
        title_result_t r;
        first = query_chars[0];
        lo    = (first < INDEX_SIZE) ? first_char_index[first] : 0;
        limit = (title_count > NUM_TITLES) ? NUM_TITLES : title_count;
        hi    = limit + 1;
        found = 1'b0;
        for (int j = first + 1; j < INDEX_SIZE; j++)
            if (!found && first_char_index[j] != 0)
            begin
                hi    = first_char_index[j];
                found = 1'b1;
            end
        if (hi > limit + 1)
            hi = limit + 1;

        if (lo == 0 || lo >= hi)
        begin
            r.status   = istsu_pkg::STATUS_NO_ENTRY;
            r.position = '0;
            r.last     = 1'b1;
            expected_titles.push_back(r);
        end
        else
            for (int p = lo; p < hi; p++)
            begin
                r.status   = title_equals_query(p - 1) ? istsu_pkg::STATUS_MATCH
                                                        : istsu_pkg::STATUS_NO_MATCH;
                r.position = p;
                r.last     = (p + 1 == hi);
                expected_titles.push_back(r);
            end
    endfunction

    // Mirror of the unit, updated on every transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TITLES*TITLE_LEN; i++)
                title_chars[i] = '0;
            for (int i = 0; i < INDEX_SIZE; i++)
                first_char_index[i] = '0;
            for (int i = 0; i < TITLE_LEN; i++)
                query_chars[i] = '0;
            query_len   = 0;
            title_count = istsu_pkg::TITLE_COUNT_RESET;
            expected_titles.delete();
            results_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                title_count = cfg_data;

            if (s_axis_tvalid && s_axis_tready)
                case (s_axis_tuser)
                    istsu_pkg::OP_TITLE:
                        if (in_slot < NUM_TITLES && in_pos < TITLE_LEN)
                            title_chars[in_slot*TITLE_LEN + in_pos] = in_char;
                    istsu_pkg::OP_INDEX:
                        if (in_char < INDEX_SIZE)
                            first_char_index[in_char] = in_ival;
                    istsu_pkg::OP_QUERY:
                    begin
                        // characters past capacity are dropped
                        if (query_len < TITLE_LEN)
                        begin
                            query_chars[query_len] = in_char;
                            query_len++;
                        end
                        if (s_axis_tlast)
                        begin
                            search_titles();
                            for (int i = 0; i < TITLE_LEN; i++)
                                query_chars[i] = '0;
                            query_len = 0;
                        end
                    end
                    default:
                        ;
                endcase

            // Compare the result transfer with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_titles.size() == 0)
                begin
                    $error("unexpected result: status %0d, title_position %0d, last %0d",
                           m_axis_tuser, m_axis_tdata[istsu_pkg::TPOS_W-1:0], m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_titles.pop_front();
                    if (m_axis_tuser !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[istsu_pkg::TPOS_W-1:0] !== oldest.position)
                    begin
                        $error("title_position: expected %0d, actual %0d", oldest.position,
                               m_axis_tdata[istsu_pkg::TPOS_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== oldest.last)
                    begin
                        $error("last: expected %0d, actual %0d", oldest.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            results_pending = expected_titles.size();
        end
    end

endmodule

/* tb/tb_indexed_sequential_title_search_unit.sv */
// ============================================================================
// tb_indexed_sequential_title_search_unit
// Drives title loads, index writes and queries into the title search unit
// with random sender gaps and receiver stalls, across several title counts,
// and reports the verdict from the failure count of the checker.
// ============================================================================
module tb_indexed_sequential_title_search_unit;

    localparam int NUM_TITLES   = 32;
    localparam int TITLE_LEN    = 128;
    localparam int INDEX_SIZE   = 256;
    localparam int RANDOM_ITEMS = 310;
    localparam int PHASES       = 6;

    localparam logic [istsu_pkg::OP_W-1:0]   OP_IGNORED = 2'd3;
    localparam logic [istsu_pkg::CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [istsu_pkg::CHAR_W-1:0] ALPHA_BASE = 8'h61;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [istsu_pkg::COUNT_W-1:0]     cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [istsu_pkg::S_DATA_W-1:0]    s_axis_tdata;
    logic [istsu_pkg::OP_W-1:0]        s_axis_tuser;
    logic                              s_axis_tlast;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [istsu_pkg::M_DATA_W-1:0]    m_axis_tdata;
    logic [istsu_pkg::STATUS_W-1:0]    m_axis_tuser;
    logic                              m_axis_tlast;

    int fail_count;
    int results_pending;
    int idle_pct;
    int stall_pct;
    int items_sent;

    // What has been written to the titles, to shape queries that can match
    logic [istsu_pkg::CHAR_W-1:0] shadow_title [NUM_TITLES][TITLE_LEN];
    logic [istsu_pkg::CHAR_W-1:0] query_text [$];

    indexed_sequential_title_search_unit #(
        .NUM_TITLES (NUM_TITLES),
        .TITLE_LEN  (TITLE_LEN),
        .INDEX_SIZE (INDEX_SIZE)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    title_search_checker #(
        .NUM_TITLES (NUM_TITLES),
        .TITLE_LEN  (TITLE_LEN),
        .INDEX_SIZE (INDEX_SIZE)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always #4 clk = ~clk;

    // Result side back-pressure
    always @(negedge clk)
        m_axis_tready = ($urandom_range(99) >= stall_pct);

    // Safety net against a hung unit
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One input transfer, after a random gap; returns at the next falling edge
    task automatic send_item(input logic [istsu_pkg::OP_W-1:0] op,
                             input logic [istsu_pkg::SLOT_W-1:0] slot,
                             input logic [istsu_pkg::POS_W-1:0] pos,
                             input logic [istsu_pkg::CHAR_W-1:0] ch,
                             input logic [istsu_pkg::IVAL_W-1:0] ival,
                             input logic last_char);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tlast  = last_char;
        s_axis_tdata  = {6'b0, ival, ch, pos, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == istsu_pkg::OP_TITLE)
            shadow_title[slot][pos] = ch;
        items_sent++;
        @(negedge clk);
    endtask

    // Query characters from query_text, last_char on the final one
    task automatic send_query_text();
        for (int i = 0; i < query_text.size(); i++)
            send_item(istsu_pkg::OP_QUERY, $urandom_range(31), $urandom_range(127),
                      query_text[i], $urandom_range(63), i == query_text.size() - 1);
    endtask

    // Register write once the unit has drained
    task automatic write_title_count(input logic [istsu_pkg::COUNT_W-1:0] value);
        s_axis_tvalid = 1'b0;
        wait (results_pending == 0);
        // trailing loads or partial query characters still leave the queue
        repeat (32) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int title_length(input int slot);
        int len;
        len = TITLE_LEN;
        for (int i = TITLE_LEN - 1; i >= 0; i--)
            if (shadow_title[slot][i] == CHAR_NUL)
                len = i;
        return len;
    endfunction

    // One random sequence: mostly loads and well-formed queries
    task automatic random_episode(input int title_limit);
        int pick;
        int slot;
        int len;
        int start;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            // short title over a small alphabet, then its terminator
            slot = $urandom_range(NUM_TITLES - 1);
            len  = $urandom_range(5);
            for (int i = 0; i < len; i++)
                send_item(istsu_pkg::OP_TITLE, slot, i, ALPHA_BASE + $urandom_range(3),
                          $urandom_range(63), $urandom_range(1));
            send_item(istsu_pkg::OP_TITLE, slot, len, CHAR_NUL, $urandom_range(63),
                      $urandom_range(1));
        end
        else if (pick < 40)
        begin
            // index entry, mostly in the alphabet and inside the loaded titles
            send_item(istsu_pkg::OP_INDEX, $urandom_range(31), $urandom_range(127),
                      ($urandom_range(4) == 0) ? $urandom_range(255)
                                               : ALPHA_BASE + $urandom_range(3),
                      ($urandom_range(3) == 0) ? $urandom_range(63)
                                               : $urandom_range(title_limit, 1),
                      $urandom_range(1));
        end
        else if (pick < 85)
        begin
            // copy of a stored title, often with its group pointed at it first
            slot = $urandom_range(NUM_TITLES - 1);
            len  = title_length(slot);
            if ($urandom_range(1) == 1)
            begin
                start = slot + 1 - $urandom_range(2);
                if (start < 1)
                    start = 1;
                send_item(istsu_pkg::OP_INDEX, 0, 0, shadow_title[slot][0], start, 1'b0);
            end
            query_text.delete();
            for (int i = 0; i < len; i++)
                query_text.push_back(shadow_title[slot][i]);
            if (len == 0)
                query_text.push_back(CHAR_NUL);
            if ($urandom_range(4) == 0)
                query_text[$urandom_range(query_text.size() - 1)] =
                    ALPHA_BASE + $urandom_range(3);
            if ($urandom_range(5) == 0)
            begin
                query_text.push_back(CHAR_NUL);
                query_text.push_back(ALPHA_BASE + $urandom_range(3));
            end
            send_query_text();
        end
        else if (pick < 95)
        begin
            // arbitrary bytes
            query_text.delete();
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++)
                query_text.push_back($urandom_range(255));
            send_query_text();
        end
        else if ($urandom_range(1) == 1)
            send_item(OP_IGNORED, $urandom_range(31), $urandom_range(127),
                      $urandom_range(255), $urandom_range(63), $urandom_range(1));
        else
            send_item(istsu_pkg::OP_TITLE, $urandom_range(31), $urandom_range(127),
                      $urandom_range(255), $urandom_range(63), $urandom_range(1));
    endtask

    // Full-length title with no terminator in the last slot, then an overlong
    // query of it whose dropped final character still starts the search
    task automatic long_title_case();
        send_item(istsu_pkg::OP_INDEX, 0, 0, 8'hFF, 0, 1'b0);
        send_item(istsu_pkg::OP_INDEX, 0, 0, 8'hFE, NUM_TITLES, 1'b0);
        query_text.delete();
        for (int i = 0; i < TITLE_LEN + 2; i++)
            query_text.push_back((i == 0) ? 8'hFE : 8'h41 + (i % 26));
        for (int i = 0; i < TITLE_LEN; i++)
            send_item(istsu_pkg::OP_TITLE, NUM_TITLES - 1, i, query_text[i], 0, 1'b0);
        send_query_text();
    endtask

    initial
    begin
        int count_value;
        int title_limit;
        int phase_start;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = istsu_pkg::OP_TITLE;
        s_axis_tlast  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        items_sent    = 0;
        for (int t = 0; t < NUM_TITLES; t++)
            for (int i = 0; i < TITLE_LEN; i++)
                shadow_title[t][i] = CHAR_NUL;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        write_title_count(istsu_pkg::TITLE_COUNT_RESET);
        send_item(istsu_pkg::OP_TITLE, 0, 0, "a", 0, 1'b0);
        send_item(istsu_pkg::OP_TITLE, 0, 1, "b", 0, 1'b0);
        send_item(istsu_pkg::OP_TITLE, 1, 0, "a", 0, 1'b0);
        send_item(istsu_pkg::OP_TITLE, 31, 127, 8'hFF, 63, 1'b1);
        send_item(istsu_pkg::OP_INDEX, 0, 0, "a", 1, 1'b0);
        send_item(istsu_pkg::OP_INDEX, 0, 0, "b", 3, 1'b0);
        // "ab" and "a" each match one title of the 'a' group
        send_item(istsu_pkg::OP_QUERY, 0, 0, "a", 0, 1'b0);
        send_item(istsu_pkg::OP_QUERY, 0, 0, "b", 0, 1'b1);
        send_item(istsu_pkg::OP_QUERY, 0, 0, "a", 0, 1'b1);
        // no index entry
        send_item(istsu_pkg::OP_QUERY, 0, 0, "c", 0, 1'b1);
        // unknown op, every field bit set
        send_item(OP_IGNORED, 31, 127, 8'hFF, 63, 1'b1);
        // group start beyond the title count
        send_item(istsu_pkg::OP_INDEX, 0, 0, 8'hFF, 63, 1'b0);
        send_item(istsu_pkg::OP_QUERY, 0, 0, 8'hFF, 0, 1'b1);
        // NUL key whose group ends before it starts
        send_item(istsu_pkg::OP_INDEX, 0, 0, CHAR_NUL, 30, 1'b0);
        send_item(istsu_pkg::OP_QUERY, 0, 0, CHAR_NUL, 0, 1'b1);
        // query cut short by an embedded NUL
        send_item(istsu_pkg::OP_QUERY, 0, 0, "a", 0, 1'b0);
        send_item(istsu_pkg::OP_QUERY, 0, 0, CHAR_NUL, 0, 1'b0);
        send_item(istsu_pkg::OP_QUERY, 0, 0, "x", 0, 1'b1);
        // cleared entry: the 'a' group runs up to the title count
        send_item(istsu_pkg::OP_INDEX, 0, 0, "b", 0, 1'b0);
        send_item(istsu_pkg::OP_QUERY, 0, 0, "a", 0, 1'b1);
        send_item(istsu_pkg::OP_INDEX, 0, 0, 8'hFF, 0, 1'b0);
        send_item(istsu_pkg::OP_INDEX, 0, 0, CHAR_NUL, 0, 1'b0);

        // Random part: one title count and one idling mode per phase
        items_sent = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       count_value = 20;
                1:       count_value = 63;
                2:       count_value = 1;
                3:       count_value = 0;
                4:       count_value = $urandom_range(31, 2);
                default: count_value = NUM_TITLES;
            endcase
            write_title_count(count_value);
            title_limit = (count_value > NUM_TITLES) ? NUM_TITLES : count_value;
            if (title_limit < 1)
                title_limit = 1;

            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default:
                begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase

            phase_start = items_sent;
            if (ph == PHASES - 1)
                long_title_case();
            while (items_sent < (ph + 1) * RANDOM_ITEMS / PHASES ||
                   items_sent - phase_start < 24)
                random_episode(title_limit);
        end

        // Drain
        s_axis_tvalid = 1'b0;
        wait (results_pending == 0);
        repeat (64) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
